// ===== rtl/clr_pkg.sv =====
package clr_pkg;

    // Coordinates on the screen are at most 7 bits; the error term needs room
    // for sums of two deltas of either sign.
    localparam int COORD_W   = 7;
    localparam int ERR_W     = 10;
    localparam int IN_W      = 16;
    localparam int COLOUR_W  = 8;
    localparam int CIDX_W    = 4;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 128;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FIRST,
        ST_SECOND
    } t_state;

    // Position and error term of the walk, carried between the sequencer and
    // the step unit.
    typedef struct packed {
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic signed [ERR_W-1:0] err;
    } t_walk;

    // Constant line geometry seen by the step unit.
    typedef struct packed {
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic               sx_pos;
        logic               sy_pos;
    } t_slope;

endpackage

// ===== rtl/clr_step.sv =====
module clr_step (
    input  clr_pkg::t_walk  i_walk,
    input  clr_pkg::t_slope i_slope,
    output clr_pkg::t_walk  o_walk
);
    import clr_pkg::*;

    logic signed [ERR_W:0]   e2;
    logic signed [ERR_W:0]   neg_dy;
    logic signed [ERR_W:0]   pos_dx;
    logic                    move_x;
    logic                    move_y;
    logic signed [ERR_W-1:0] dx_s;
    logic signed [ERR_W-1:0] dy_s;

    always_comb begin
        dx_s   = $signed({{(ERR_W-COORD_W){1'b0}}, i_slope.dx});
        dy_s   = $signed({{(ERR_W-COORD_W){1'b0}}, i_slope.dy});
        e2     = $signed({i_walk.err, 1'b0});
        neg_dy = -$signed({{(ERR_W+1-COORD_W){1'b0}}, i_slope.dy});
        pos_dx = $signed({{(ERR_W+1-COORD_W){1'b0}}, i_slope.dx});
        move_x = e2 > neg_dy;
        move_y = e2 < pos_dx;

        o_walk.err = i_walk.err - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
        if (move_x) begin
            o_walk.x = i_slope.sx_pos ? i_walk.x + 1'b1 : i_walk.x - 1'b1;
        end else begin
            o_walk.x = i_walk.x;
        end
        if (move_y) begin
            o_walk.y = i_slope.sy_pos ? i_walk.y + 1'b1 : i_walk.y - 1'b1;
        end else begin
            o_walk.y = i_walk.y;
        end
    end

endmodule

// ===== rtl/clamped_line_rasterizer.sv =====
// Line rasteriser with screen clamping. A command is taken when start is high
// and busy is low; its four signed coordinates are clamped into the screen and
// the Bresenham walk then runs from the start point up to, but not including,
// the end point. Pixels come out two to a beat on the o_first_* and o_second_*
// ports, each beat shown for exactly one cycle under o_valid; the receiver
// cannot hold a beat off, so it must take every beat as it appears. The final
// beat of a line carries o_last, and a line whose clamped endpoints coincide
// yields no beat at all. A single step unit advances the walk by one pixel per
// cycle while the line is walked: busy is high through ST_SETUP and then, for
// each beat, ST_FIRST and ST_SECOND; a zero-length line leaves after ST_SETUP.
// The last beat is on the ports in the first cycle with busy low, so a new
// command may already be taken while it is on the ports.
module clamped_line_rasterizer #(
    parameter int SCREEN_WIDTH  = clr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = clr_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [clr_pkg::IN_W-1:0]     i_start_x,
    input  logic signed [clr_pkg::IN_W-1:0]     i_start_y,
    input  logic signed [clr_pkg::IN_W-1:0]     i_end_x,
    input  logic signed [clr_pkg::IN_W-1:0]     i_end_y,
    input  logic [clr_pkg::COLOUR_W-1:0]        i_colour,
    output logic                                o_valid,
    output logic [clr_pkg::COORD_W-1:0]         o_first_x,
    output logic [clr_pkg::COORD_W-1:0]         o_first_y,
    output logic [clr_pkg::COORD_W-1:0]         o_second_x,
    output logic [clr_pkg::COORD_W-1:0]         o_second_y,
    output logic                                o_second_valid,
    output logic [clr_pkg::CIDX_W-1:0]          o_colour_index,
    output logic                                o_last
);
    import clr_pkg::*;

    // Screen limits widened by one bit so that a limit of 128 is representable.
    localparam logic [COORD_W:0] LIM_X = (COORD_W+1)'(SCREEN_WIDTH);
    localparam logic [COORD_W:0] LIM_Y = (COORD_W+1)'(SCREEN_HEIGHT);

    // Clamp a signed coordinate into 0 .. lim-1.
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [IN_W-1:0] v,
        input logic [COORD_W:0]       lim
    );
        logic signed [IN_W-1:0] lim_s;
        lim_s = $signed({{(IN_W-COORD_W-1){1'b0}}, lim});
        if (v < 0) begin
            return '0;
        end else if (v >= lim_s) begin
            return COORD_W'(lim - 1'b1);
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

    t_state             r_state, n_state;
    t_walk              r_walk, n_walk;
    t_walk              step_walk;
    t_slope             r_slope, n_slope;
    logic [COORD_W-1:0] r_end_x, n_end_x;
    logic [COORD_W-1:0] r_end_y, n_end_y;
    logic [CIDX_W-1:0]  r_cidx, n_cidx;
    logic [COORD_W-1:0] r_hold_x, n_hold_x;
    logic [COORD_W-1:0] r_hold_y, n_hold_y;

    logic               r_valid, n_valid;
    logic [COORD_W-1:0] r_first_x, n_first_x;
    logic [COORD_W-1:0] r_first_y, n_first_y;
    logic [COORD_W-1:0] r_second_x, n_second_x;
    logic [COORD_W-1:0] r_second_y, n_second_y;
    logic               r_second_valid, n_second_valid;
    logic [CIDX_W-1:0]  r_colour_index, n_colour_index;
    logic               r_last, n_last;

    logic [COORD_W-1:0] dx_c, dy_c;
    logic               at_end, step_at_end;

    // One Bresenham step per cycle, shared by both pixel slots of a beat.
    clr_step u_step (
        .i_walk  (r_walk),
        .i_slope (r_slope),
        .o_walk  (step_walk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Payload and walk registers need no reset.
    always_ff @(posedge i_clk) begin
        r_walk         <= n_walk;
        r_slope        <= n_slope;
        r_end_x        <= n_end_x;
        r_end_y        <= n_end_y;
        r_cidx         <= n_cidx;
        r_hold_x       <= n_hold_x;
        r_hold_y       <= n_hold_y;
        r_first_x      <= n_first_x;
        r_first_y      <= n_first_y;
        r_second_x     <= n_second_x;
        r_second_y     <= n_second_y;
        r_second_valid <= n_second_valid;
        r_colour_index <= n_colour_index;
        r_last         <= n_last;
    end

    always_comb begin
        n_state        = r_state;
        n_walk         = r_walk;
        n_slope        = r_slope;
        n_end_x        = r_end_x;
        n_end_y        = r_end_y;
        n_cidx         = r_cidx;
        n_hold_x       = r_hold_x;
        n_hold_y       = r_hold_y;
        n_valid        = 1'b0;
        n_first_x      = r_first_x;
        n_first_y      = r_first_y;
        n_second_x     = r_second_x;
        n_second_y     = r_second_y;
        n_second_valid = r_second_valid;
        n_colour_index = r_colour_index;
        n_last         = r_last;

        // Absolute deltas from the start point held in the walk registers.
        dx_c = (r_walk.x > r_end_x) ? r_walk.x - r_end_x : r_end_x - r_walk.x;
        dy_c = (r_walk.y > r_end_y) ? r_walk.y - r_end_y : r_end_y - r_walk.y;

        at_end      = (r_walk.x == r_end_x) && (r_walk.y == r_end_y);
        step_at_end = (step_walk.x == r_end_x) && (step_walk.y == r_end_y);

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_walk.x = clamp_coord(i_start_x, LIM_X);
                    n_walk.y = clamp_coord(i_start_y, LIM_Y);
                    n_end_x  = clamp_coord(i_end_x, LIM_X);
                    n_end_y  = clamp_coord(i_end_y, LIM_Y);
                    n_cidx   = i_colour[CIDX_W-1:0];
                    n_state  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_slope.dx     = dx_c;
                n_slope.dy     = dy_c;
                n_slope.sx_pos = r_walk.x < r_end_x;
                n_slope.sy_pos = r_walk.y < r_end_y;
                n_walk.err     = $signed({{(ERR_W-COORD_W){1'b0}}, dx_c})
                               - $signed({{(ERR_W-COORD_W){1'b0}}, dy_c});
                // A zero-length line produces no beat.
                n_state        = at_end ? ST_IDLE : ST_FIRST;
            end
            ST_FIRST: begin
                // The walk is never at the end point here.
                n_hold_x = r_walk.x;
                n_hold_y = r_walk.y;
                n_walk   = step_walk;
                n_state  = ST_SECOND;
            end
            ST_SECOND: begin
                n_valid        = 1'b1;
                n_first_x      = r_hold_x;
                n_first_y      = r_hold_y;
                n_colour_index = r_cidx;
                if (at_end) begin
                    // Odd pixel count: the final beat holds a single pixel.
                    n_second_x     = '0;
                    n_second_y     = '0;
                    n_second_valid = 1'b0;
                    n_last         = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_second_x     = r_walk.x;
                    n_second_y     = r_walk.y;
                    n_second_valid = 1'b1;
                    n_last         = step_at_end;
                    n_walk         = step_walk;
                    n_state        = step_at_end ? ST_IDLE : ST_FIRST;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_first_x      = r_first_x;
    assign o_first_y      = r_first_y;
    assign o_second_x     = r_second_x;
    assign o_second_y     = r_second_y;
    assign o_second_valid = r_second_valid;
    assign o_colour_index = r_colour_index;
    assign o_last         = r_last;

endmodule

// ===== rtl/clr_checker.sv =====
module clr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [clr_pkg::COORD_W-1:0] o_second_x,
    input logic [clr_pkg::COORD_W-1:0] o_second_y,
    input logic                        o_second_valid,
    input logic                        o_last
);
    import clr_pkg::*;

    // A taken command makes the block busy in the cycle after it is taken.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("command taken but block not busy");

    // Every beat belongs to a line that was being walked in the cycle before.
    a_beat_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("beat without a line in progress");

    // More beats follow a beat that is not the last, so the block stays busy.
    a_more_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("line ended without a last beat");

    // A single-pixel beat can only close a line, and its second slot is zero.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_second_valid |-> o_last && o_second_x == '0 && o_second_y == '0)
        else $error("single-pixel beat malformed");

endmodule

bind clamped_line_rasterizer clr_checker u_clr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_second_x     (o_second_x),
    .o_second_y     (o_second_y),
    .o_second_valid (o_second_valid),
    .o_last         (o_last)
);

// ===== sim/clr_line_checker.sv =====
`timescale 1ns / 100ps

// Watches the command and pixel channels of the line rasteriser, walks each
// accepted line itself and compares every beat with the pixel pair it expects.
module clr_line_checker
    import clr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic signed [IN_W-1:0]     i_start_x,
    input  logic signed [IN_W-1:0]     i_start_y,
    input  logic signed [IN_W-1:0]     i_end_x,
    input  logic signed [IN_W-1:0]     i_end_y,
    input  logic [COLOUR_W-1:0]        i_colour,
    input  logic                       i_valid,
    input  logic [COORD_W-1:0]         i_first_x,
    input  logic [COORD_W-1:0]         i_first_y,
    input  logic [COORD_W-1:0]         i_second_x,
    input  logic [COORD_W-1:0]         i_second_y,
    input  logic                       i_second_valid,
    input  logic [CIDX_W-1:0]          i_colour_index,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_lines,
    output int                         o_beats
);

    localparam int PALETTE_SIZE = 16;
    localparam int MAX_PIXELS   = 128;

    typedef struct packed {
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        logic               second_valid;
        logic [CIDX_W-1:0]  colour_index;
        logic               last;
    } t_pixel_pair;

    t_pixel_pair pair_q[$];
    int          fails = 0;
    int          lines = 0;
    int          beats = 0;

    function automatic int clamp_coord(input int v, input int lim);
        if (v < 0) begin
            return 0;
        end
        if (v >= lim) begin
            return lim - 1;
        end
        return v;
    endfunction

    // Walks the clamped line with the Bresenham error term and queues the
    // pixel pairs, end point excluded.
    function automatic void walk_line(input int sx, input int sy, input int ex,
                                      input int ey, input logic [COLOUR_W-1:0] col);
        int          x;
        int          y;
        int          xe;
        int          ye;
        int          dx;
        int          dy;
        int          stx;
        int          sty;
        int          err;
        int          e2;
        int          n;
        int          px[MAX_PIXELS];
        int          py[MAX_PIXELS];
        t_pixel_pair pp;
        x   = clamp_coord(sx, SCREEN_WIDTH);
        y   = clamp_coord(sy, SCREEN_HEIGHT);
        xe  = clamp_coord(ex, SCREEN_WIDTH);
        ye  = clamp_coord(ey, SCREEN_HEIGHT);
        dx  = (x > xe) ? x - xe : xe - x;
        dy  = (y > ye) ? y - ye : ye - y;
        stx = (x < xe) ? 1 : -1;
        sty = (y < ye) ? 1 : -1;
        err = dx - dy;
        n   = 0;
        while ((x != xe || y != ye) && n < MAX_PIXELS) begin
            px[n] = x;
            py[n] = y;
            n++;
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                x   += stx;
            end
            if (e2 < dx) begin
                err += dx;
                y   += sty;
            end
        end
        for (int k = 0; k < n; k += 2) begin
            pp              = '0;
            pp.first_x      = px[k][COORD_W-1:0];
            pp.first_y      = py[k][COORD_W-1:0];
            if (k + 1 < n) begin
                pp.second_x     = px[k+1][COORD_W-1:0];
                pp.second_y     = py[k+1][COORD_W-1:0];
                pp.second_valid = 1'b1;
            end
            pp.colour_index = CIDX_W'(col % PALETTE_SIZE);
            pp.last         = (k + 2 >= n);
            pair_q.push_back(pp);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_pair want;
        if (i_rst_n) begin
            // The old beat is compared before a command taken at the same edge
            // queues its own pairs.
            if (i_valid) begin
                beats++;
                if (pair_q.size() == 0) begin
                    report_mismatch("beat arrived with no pixel pair pending");
                end else begin
                    want = pair_q.pop_front();
                    compare_field("first_x", i_first_x, want.first_x);
                    compare_field("first_y", i_first_y, want.first_y);
                    compare_field("second_x", i_second_x, want.second_x);
                    compare_field("second_y", i_second_y, want.second_y);
                    compare_field("second_valid", i_second_valid, want.second_valid);
                    compare_field("colour_index", i_colour_index, want.colour_index);
                    compare_field("last", i_last, want.last);
                end
            end
            if (i_start && !i_busy) begin
                lines++;
                walk_line(i_start_x, i_start_y, i_end_x, i_end_y, i_colour);
            end
        end
        o_fail_count <= fails;
        o_pending    <= pair_q.size();
        o_lines      <= lines;
        o_beats      <= beats;
    end

endmodule

// ===== sim/tb_clamped_line_rasterizer.sv =====
`timescale 1ns / 100ps

// Top level of the rasteriser test. This module only makes commands and
// delivers the verdict; all prediction and comparison happens in the checker
// that sits beside the block and watches both channels.
module tb_clamped_line_rasterizer;
    import clr_pkg::*;

    // Room after the drain for the longest line and its last beat, which shows
    // as busy falls.
    localparam int TAIL_CYCLES  = 140;
    localparam int DRAIN_LIMIT  = 2000;
    // Slowest plausible run is about 130 lines; the limit allows many times
    // its length.
    localparam int CYCLE_LIMIT  = 200000;

    // Random lines per sender idle setting.
    localparam int RAND_PHASE_A = 40;
    localparam int RAND_PHASE_B = 40;
    localparam int RAND_PHASE_C = 30;

    logic                    i_clk;
    logic                    i_rst_n   = 1'b0;
    logic                    start     = 1'b0;
    logic                    busy;
    logic signed [IN_W-1:0]  i_start_x = '0;
    logic signed [IN_W-1:0]  i_start_y = '0;
    logic signed [IN_W-1:0]  i_end_x   = '0;
    logic signed [IN_W-1:0]  i_end_y   = '0;
    logic [COLOUR_W-1:0]     i_colour  = '0;
    logic                    o_valid;
    logic [COORD_W-1:0]      o_first_x;
    logic [COORD_W-1:0]      o_first_y;
    logic [COORD_W-1:0]      o_second_x;
    logic [COORD_W-1:0]      o_second_y;
    logic                    o_second_valid;
    logic [CIDX_W-1:0]       o_colour_index;
    logic                    o_last;

    int fail_count;
    int pending;
    int lines_seen;
    int beats_seen;

    int idle_pct    = 18;
    int n_directed  = 0;
    int n_random    = 0;
    int cycle_count = 0;

    clamped_line_rasterizer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_colour       (i_colour),
        .o_valid        (o_valid),
        .o_first_x      (o_first_x),
        .o_first_y      (o_first_y),
        .o_second_x     (o_second_x),
        .o_second_y     (o_second_y),
        .o_second_valid (o_second_valid),
        .o_colour_index (o_colour_index),
        .o_last         (o_last)
    );

    clr_line_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_colour       (i_colour),
        .i_valid        (o_valid),
        .i_first_x      (o_first_x),
        .i_first_y      (o_first_y),
        .i_second_x     (o_second_x),
        .i_second_y     (o_second_y),
        .i_second_valid (o_second_valid),
        .i_colour_index (o_colour_index),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_lines        (lines_seen),
        .o_beats        (beats_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost beat must not stall the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", CYCLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offers one line command and returns at the edge that accepts it. Before
    // raising start the sender idles for as long as a random draw in 0..99
    // falls under idle_pct. Start is left high on return so that a following
    // command goes out back to back; it is only ever given one new value per
    // clock edge.
    task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                             input int col);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_start_x <= sx[IN_W-1:0];
        i_start_y <= sy[IN_W-1:0];
        i_end_x   <= ex[IN_W-1:0];
        i_end_y   <= ey[IN_W-1:0];
        i_colour  <= col[COLOUR_W-1:0];
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Most coordinates land on the screen so that the lines carry real work;
    // the rest sit just off the edges, anywhere in the 16-bit range, or on the
    // exact limits of clamping.
    function automatic int pick_coord(input int lim);
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            return $urandom_range(lim - 1);
        end else if (r < 75) begin
            return int'($urandom_range(lim + 15)) - 8;
        end else if (r < 90) begin
            return int'($signed(16'($urandom)));
        end
        case ($urandom_range(5))
            0:       return -32768;
            1:       return 32767;
            2:       return -1;
            3:       return 0;
            4:       return lim - 1;
            default: return lim;
        endcase
    endfunction

    // A random line: mostly general slopes, with a share of axis-aligned and
    // of zero-length lines.
    task automatic send_random_line();
        int sx;
        int sy;
        int ex;
        int ey;
        int shape;
        sx    = pick_coord(DEF_SCREEN_WIDTH);
        sy    = pick_coord(DEF_SCREEN_HEIGHT);
        ex    = pick_coord(DEF_SCREEN_WIDTH);
        ey    = pick_coord(DEF_SCREEN_HEIGHT);
        shape = $urandom_range(99);
        if (shape < 8) begin
            ex = sx;
            ey = sy;
        end else if (shape < 14) begin
            ey = sy;
        end else if (shape < 20) begin
            ex = sx;
        end
        send_line(sx, sy, ex, ey, $urandom_range(255));
        n_random++;
    endtask

    initial begin
        int waited;

        // Synchronous reset, held low from time zero and then released.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines. Zero-length first, both plain and after clamping,
        // then the full-screen diagonals, axis-aligned lines both ways (some
        // clamped from far outside), one- and two-pixel lines, steep and
        // shallow slopes in all directions, and colour bytes that between
        // them set and clear every bit.
        send_line(5, 5, 5, 5, 8'h00);
        send_line(-100, -3, -1, -200, 8'hFF);
        send_line(-32768, -32768, 32767, 32767, 8'h0F);
        send_line(32767, -32768, -32768, 32767, 8'hF0);
        send_line(0, 10, 127, 10, 8'hAA);
        send_line(200, 10, -5, 10, 8'h55);
        send_line(20, 0, 20, 127, 8'h01);
        send_line(20, 32767, 20, -32768, 8'h80);
        send_line(3, 4, 4, 4, 8'h10);
        send_line(3, 4, 5, 4, 8'h1F);
        send_line(4, 4, 3, 3, 8'h3C);
        send_line(10, 10, 13, 50, 8'hC3);
        send_line(90, 17, 10, 10, 8'h7E);
        send_line(10, 100, 90, 80, 8'h81);
        send_line(60, 5, 55, 120, 8'h42);
        send_line(127, 127, 128, -1, 8'h99);
        send_line(-1, 0, 0, 127, 8'h66);
        send_line(0, 0, 1, 2, 8'h24);
        send_line(0, 0, 2, 1, 8'hDB);
        // A zero-length line straight after another line lands while the last
        // beat of the previous line may still be on the ports.
        send_line(64, 64, 64, 64, 8'hE7);
        n_directed = 20;

        // Random lines under three sender settings: occasional gaps, frequent
        // gaps, then commands offered back to back.
        repeat (RAND_PHASE_A) send_random_line();
        idle_pct = 72;
        repeat (RAND_PHASE_B) send_random_line();
        idle_pct = 0;
        repeat (RAND_PHASE_C) send_random_line();
        start <= 1'b0;

        // Drain: wait for every expected pixel pair, then leave room for any
        // stray beat from a line that should have produced nothing.
        waited = 0;
        @(posedge i_clk);
        while ((pending != 0 || busy) && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending != 0) begin
            $display("%0d expected pixel pairs never arrived.", pending);
        end
        $display("Ran %0d line commands (%0d directed, %0d random), three gap settings.",
                 lines_seen, n_directed, n_random);
        $display("Checked %0d pixel-pair beats field by field; %0d mismatches.",
                 beats_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
